// ===== hw/rtl/slbc_pkg.sv =====
// slbc_pkg: shared types and constants of the status LED blink controller
// used by slbc_cfg_regs, slbc_core and status_led_blink_controller
`default_nettype none

package slbc_pkg;

    // configuration register widths and reset values
    localparam int CFG_W            = 16;
    localparam int POL_W            = 3;
    localparam int CFG_IDX_W        = 2;
    localparam int TIMER_WIDTH_DEF  = 16;

    localparam logic [CFG_W-1:0] NETWORK_BLINK_RST = 16'd500;
    localparam logic [CFG_W-1:0] CLIENT_BLINK_RST  = 16'd500;
    localparam logic [CFG_W-1:0] BATTERY_CYCLE_RST = 16'd1000;
    localparam logic [POL_W-1:0] ACTIVE_HIGH_RST   = 3'd7;

    // stream widths
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NETWORK_BLINK = 2'd0,
        CFG_CLIENT_BLINK  = 2'd1,
        CFG_BATTERY_CYCLE = 2'd2,
        CFG_ACTIVE_HIGH   = 2'd3
    } cfg_idx_t;

    // event kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK     = 3'd0,
        KIND_SET_MODE = 3'd1,
        KIND_NETWORK  = 3'd2,
        KIND_CLIENT   = 3'd3,
        KIND_BATTERY  = 3'd4
    } kind_t;

    // operating modes
    typedef enum logic [1:0] {
        MODE_OTHER   = 2'd0,
        MODE_NETWORK = 2'd1,
        MODE_CLIENT  = 2'd2
    } mode_t;

    // configuration bundle
    typedef struct packed {
        logic [CFG_W-1:0] network_blink;
        logic [CFG_W-1:0] client_blink;
        logic [CFG_W-1:0] battery_cycle;
        logic [POL_W-1:0] active_high;
    } cfg_t;

    // logical LED states (before polarity)
    typedef struct packed {
        logic battery;
        logic client;
        logic network;
    } led_on_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slbc_cfg_regs.sv =====
// slbc_cfg_regs: configuration register file of the LED blink controller
// depends on slbc_pkg
`default_nettype none

module slbc_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slbc_pkg::CFG_W-1:0]     cfg_wdata,
    output slbc_pkg::cfg_t                     cfg
);

    slbc_pkg::cfg_t cfg_reg;
    slbc_pkg::cfg_t cfg_next;

    // decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (slbc_pkg::cfg_idx_t'(cfg_index))
                slbc_pkg::CFG_NETWORK_BLINK: cfg_next.network_blink = cfg_wdata;
                slbc_pkg::CFG_CLIENT_BLINK:  cfg_next.client_blink  = cfg_wdata;
                slbc_pkg::CFG_BATTERY_CYCLE: cfg_next.battery_cycle = cfg_wdata;
                slbc_pkg::CFG_ACTIVE_HIGH:
                    cfg_next.active_high = cfg_wdata[slbc_pkg::POL_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // register file with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.network_blink <= slbc_pkg::NETWORK_BLINK_RST;
            cfg_reg.client_blink  <= slbc_pkg::CLIENT_BLINK_RST;
            cfg_reg.battery_cycle <= slbc_pkg::BATTERY_CYCLE_RST;
            cfg_reg.active_high   <= slbc_pkg::ACTIVE_HIGH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/slbc_core.sv =====
// slbc_core: mode, link and warning state plus blink timers; one event per cycle while evt_fire is high
// depends on slbc_pkg
`default_nettype none

module slbc_core #(
    parameter int TIMER_WIDTH = slbc_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           evt_fire,
    input  wire logic [slbc_pkg::KIND_W-1:0]    evt_kind,
    input  wire logic [slbc_pkg::VALUE_W-1:0]   evt_value,
    input  wire slbc_pkg::cfg_t                 cfg,
    output slbc_pkg::led_on_t                   led_next
);

    // compare width covers both timer and interval registers
    localparam int CMP_W = (TIMER_WIDTH > slbc_pkg::CFG_W) ? TIMER_WIDTH : slbc_pkg::CFG_W;
    localparam logic [CMP_W-1:0] TMAX = CMP_W'({TIMER_WIDTH{1'b1}});

    slbc_pkg::mode_t          mode_reg,        mode_next;
    logic                     network_up_reg,  network_up_next;
    logic                     client_up_reg,   client_up_next;
    logic                     warning_reg,     warning_next;
    logic                     phase_reg,       phase_next;
    slbc_pkg::led_on_t        led_reg,         led_upd;
    logic [TIMER_WIDTH-1:0]   blink_cnt_reg,   blink_cnt_next;
    logic [TIMER_WIDTH-1:0]   bat_cnt_reg,     bat_cnt_next;

    // saturating count toward min(interval, timer max)
    function automatic logic [TIMER_WIDTH-1:0] sat_inc(
        input logic [TIMER_WIDTH-1:0]     cnt,
        input logic [slbc_pkg::CFG_W-1:0] iv
    );
        logic [CMP_W-1:0] limit;
        limit = (CMP_W'(iv) > TMAX) ? TMAX : CMP_W'(iv);
        if (CMP_W'(cnt) < limit) begin
            return cnt + TIMER_WIDTH'(1);
        end
        return cnt;
    endfunction

    // counter reached its interval
    function automatic logic reached(
        input logic [TIMER_WIDTH-1:0]     cnt,
        input logic [slbc_pkg::CFG_W-1:0] iv
    );
        return CMP_W'(cnt) >= CMP_W'(iv);
    endfunction

    // mode LED write, other mode LED forced off
    function automatic slbc_pkg::led_on_t drive_mode(
        input slbc_pkg::led_on_t cur,
        input slbc_pkg::mode_t   mode,
        input logic              on
    );
        slbc_pkg::led_on_t r;
        r = cur;
        r.network = (mode == slbc_pkg::MODE_NETWORK) ? on : 1'b0;
        r.client  = (mode == slbc_pkg::MODE_CLIENT)  ? on : 1'b0;
        return r;
    endfunction

    // event update
    always_comb begin
        logic [slbc_pkg::CFG_W-1:0] blink_iv;
        logic                       flag;
        mode_next       = mode_reg;
        network_up_next = network_up_reg;
        client_up_next  = client_up_reg;
        warning_next    = warning_reg;
        phase_next      = phase_reg;
        led_upd         = led_reg;
        blink_cnt_next  = blink_cnt_reg;
        bat_cnt_next    = bat_cnt_reg;
        flag            = (evt_value != '0);
        blink_iv        = (mode_reg == slbc_pkg::MODE_CLIENT) ? cfg.client_blink
                                                              : cfg.network_blink;
        case (slbc_pkg::kind_t'(evt_kind))
            slbc_pkg::KIND_TICK: begin
                blink_cnt_next = sat_inc(blink_cnt_reg, blink_iv);
                bat_cnt_next   = sat_inc(bat_cnt_reg, cfg.battery_cycle);
                if (warning_reg) begin
                    if (reached(bat_cnt_next, cfg.battery_cycle)) begin
                        bat_cnt_next = '0;
                        phase_next   = !phase_reg;
                    end
                    led_upd.battery = phase_next;
                    led_upd = drive_mode(led_upd, mode_reg, !phase_next);
                end else begin
                    led_upd.battery = 1'b0;
                    if (mode_reg == slbc_pkg::MODE_NETWORK) begin
                        if (network_up_reg) begin
                            led_upd.network = 1'b1;
                        end else if (reached(blink_cnt_next, blink_iv)) begin
                            blink_cnt_next  = '0;
                            led_upd.network = !led_reg.network;
                        end
                    end else if (mode_reg == slbc_pkg::MODE_CLIENT) begin
                        if (client_up_reg) begin
                            led_upd.client = 1'b1;
                        end else if (reached(blink_cnt_next, blink_iv)) begin
                            blink_cnt_next = '0;
                            led_upd.client = !led_reg.client;
                        end
                    end
                end
            end
            slbc_pkg::KIND_SET_MODE: begin
                case (evt_value)
                    slbc_pkg::MODE_NETWORK: mode_next = slbc_pkg::MODE_NETWORK;
                    slbc_pkg::MODE_CLIENT:  mode_next = slbc_pkg::MODE_CLIENT;
                    default:                mode_next = slbc_pkg::MODE_OTHER;
                endcase
                network_up_next = 1'b0;
                client_up_next  = 1'b0;
                blink_cnt_next  = '0;
                bat_cnt_next    = '0;
                phase_next      = 1'b0;
                led_upd         = '0;
            end
            slbc_pkg::KIND_NETWORK: begin
                if (network_up_reg != flag) begin
                    network_up_next = flag;
                    blink_cnt_next  = '0;
                    if (mode_reg == slbc_pkg::MODE_NETWORK) begin
                        if (warning_reg) begin
                            led_upd = drive_mode(led_reg, mode_reg, !phase_reg);
                        end else begin
                            led_upd.network = flag;
                        end
                    end
                end
            end
            slbc_pkg::KIND_CLIENT: begin
                if (client_up_reg != flag) begin
                    client_up_next = flag;
                    blink_cnt_next = '0;
                    if (mode_reg == slbc_pkg::MODE_CLIENT) begin
                        if (warning_reg) begin
                            led_upd = drive_mode(led_reg, mode_reg, !phase_reg);
                        end else begin
                            led_upd.client = flag;
                        end
                    end
                end
            end
            slbc_pkg::KIND_BATTERY: begin
                if (warning_reg != flag) begin
                    warning_next    = flag;
                    bat_cnt_next    = '0;
                    phase_next      = 1'b0;
                    led_upd.battery = 1'b0;
                    if (!flag) begin
                        if (mode_reg == slbc_pkg::MODE_NETWORK) begin
                            led_upd.network = network_up_reg;
                        end else if (mode_reg == slbc_pkg::MODE_CLIENT) begin
                            led_upd.client = client_up_reg;
                        end
                    end
                end
            end
            default: begin
                led_upd = led_reg;
            end
        endcase
    end

    // state registers, updated once per event transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= slbc_pkg::MODE_OTHER;
            network_up_reg <= 1'b0;
            client_up_reg  <= 1'b0;
            warning_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            led_reg        <= '0;
            blink_cnt_reg  <= '0;
            bat_cnt_reg    <= '0;
        end else if (evt_fire) begin
            mode_reg       <= mode_next;
            network_up_reg <= network_up_next;
            client_up_reg  <= client_up_next;
            warning_reg    <= warning_next;
            phase_reg      <= phase_next;
            led_reg        <= led_upd;
            blink_cnt_reg  <= blink_cnt_next;
            bat_cnt_reg    <= bat_cnt_next;
        end
    end

    assign led_next = led_upd;

endmodule

`default_nettype wire

// ===== hw/rtl/status_led_blink_controller.sv =====
// status_led_blink_controller: top level with event stream, LED level stream
// depends on slbc_pkg, slbc_cfg_regs, slbc_core
//
// Usage:
//   s_ channel carries events: s_tuser is the event kind (tick, set mode,
//   network link, client link, low battery), s_tdata holds the value.
//   m_ channel returns one item per event: the three LED pin levels after
//   polarity. Configuration is written through cfg_we / cfg_index /
//   cfg_wdata while no event is in flight.
//   An event transferred on s_ is held in the input register, and its result
//   in the result register that drives m_tvalid. Throughput: one event per
//   cycle while the receiver does not stall, set by the single registered
//   update pass from the input register to the result register. When the
//   receiver stalls, the result register holds its item and the input
//   register still takes one more event; s_tready drops only when both are full.
//   Reset (aresetn low, synchronous): all LED, link, mode and timer state
//   clears, configuration returns to its defaults (500, 500, 1000 ticks,
//   all LEDs active high), and both channels empty.
`default_nettype none

module status_led_blink_controller #(
    parameter int TIMER_WIDTH = slbc_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // event channel
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [slbc_pkg::IN_DATA_W-1:0]     s_tdata,   // [1:0] value
    input  wire logic [slbc_pkg::KIND_W-1:0]        s_tuser,   // [2:0] kind
    // LED level channel
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [slbc_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] network_led_level,
                                                               // [1] client_led_level,
                                                               // [2] battery_led_level
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [slbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [slbc_pkg::CFG_W-1:0]         cfg_wdata
);

    slbc_pkg::cfg_t                   cfg;
    slbc_pkg::led_on_t                led_next;

    logic                             in_valid_reg;
    logic [slbc_pkg::KIND_W-1:0]      in_kind_reg;
    logic [slbc_pkg::VALUE_W-1:0]     in_value_reg;
    logic                             out_valid_reg;
    logic [slbc_pkg::POL_W-1:0]       out_level_reg;
    logic [slbc_pkg::POL_W-1:0]       out_level_next;
    logic                             advance;
    logic                             in_xfer;

    // pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_kind_reg  <= s_tuser;
            in_value_reg <= s_tdata[slbc_pkg::VALUE_W-1:0];
        end
    end

    slbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slbc_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt_fire  (advance),
        .evt_kind  (in_kind_reg),
        .evt_value (in_value_reg),
        .cfg       (cfg),
        .led_next  (led_next)
    );

    // polarity: pin = on xor not active_high
    assign out_level_next = {led_next.battery, led_next.client, led_next.network}
                            ^ ~cfg.active_high;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_level_reg <= out_level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(slbc_pkg::OUT_DATA_W - slbc_pkg::POL_W){1'b0}}, out_level_reg};

endmodule

`default_nettype wire
